### hdl/mfd_pkg.sv
package mfd_pkg;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_S_C,
    PH_S_A,
    PH_S_CS,
    PH_S_STOP,
    PH_L_LEN1,
    PH_L_LEN2,
    PH_L_START2,
    PH_L_BODY,
    PH_L_CS,
    PH_L_STOP
  } phase_e;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  localparam logic [2:0] CAUSE_NONE   = 3'd0;
  localparam logic [2:0] CAUSE_START  = 3'd1;
  localparam logic [2:0] CAUSE_HEADER = 3'd2;
  localparam logic [2:0] CAUSE_STOP   = 3'd3;
  localparam logic [2:0] CAUSE_SUM    = 3'd4;
  localparam logic [2:0] CAUSE_TRUNC  = 3'd5;

  localparam logic [1:0] CFG_ACK         = 2'd0;
  localparam logic [1:0] CFG_SHORT_START = 2'd1;
  localparam logic [1:0] CFG_LONG_START  = 2'd2;
  localparam logic [1:0] CFG_STOP        = 2'd3;

  localparam logic [7:0] ACK_RST         = 8'hE5;
  localparam logic [7:0] SHORT_START_RST = 8'h10;
  localparam logic [7:0] LONG_START_RST  = 8'h68;
  localparam logic [7:0] STOP_RST        = 8'h16;

  localparam logic [7:0] L_MIN        = 8'd3;
  localparam logic [8:0] FRAME_EXTRA  = 9'd6;
  localparam logic [8:0] OCTETS_ACK   = 9'd1;
  localparam logic [8:0] OCTETS_SHORT = 9'd5;

  typedef struct packed {
    logic [7:0] ack_code;
    logic [7:0] short_start_code;
    logic [7:0] long_start_code;
    logic [7:0] stop_code;
  } cfg_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_done;
    logic       frame_ok;
    logic [2:0] error_cause;
    logic [1:0] frame_kind;
    logic [7:0] control_field;
    logic [7:0] address_field;
    logic [7:0] ci_field;
    logic [7:0] user_data_length;
    logic [8:0] frame_octets;
  } result_t;

endpackage

### hdl/mfd_parser.sv
module mfd_parser import mfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  logic       buffer_end_i,
  input  cfg_t       cfg_i,
  output logic       has_result_o,
  output result_t    result_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] length_q, length_d;
  logic [7:0] body_count_q, body_count_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] ctl_q, ctl_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] ci_q, ci_d;
  logic       sum_ok_q, sum_ok_d;

  logic       good, err, data, bad_phase;
  logic [2:0] cause;
  logic [1:0] kind;
  logic [7:0] body_next;

  assign body_next = body_count_q + 8'd1;

  // phase sequencing and frame decisions
  always_comb begin
    phase_d   = phase_q;
    good      = 1'b0;
    err       = 1'b0;
    data      = 1'b0;
    bad_phase = 1'b0;
    cause     = CAUSE_NONE;
    kind      = (phase_q >= PH_L_LEN1) ? KIND_LONG : KIND_SHORT;
    unique case (phase_q) inside
      PH_HUNT: begin
        if (rx_byte_i == cfg_i.ack_code) begin
          good = 1'b1;
          kind = KIND_ACK;
        end else if (rx_byte_i == cfg_i.short_start_code) begin
          phase_d = PH_S_C;
          kind    = KIND_SHORT;
        end else if (rx_byte_i == cfg_i.long_start_code) begin
          phase_d = PH_L_LEN1;
          kind    = KIND_LONG;
        end else begin
          err   = 1'b1;
          cause = CAUSE_START;
          kind  = KIND_ACK;
        end
      end
      PH_S_C:  phase_d = PH_S_A;
      PH_S_A:  phase_d = PH_S_CS;
      PH_S_CS: phase_d = PH_S_STOP;
      PH_S_STOP, PH_L_STOP: begin
        if (rx_byte_i != cfg_i.stop_code) begin
          err   = 1'b1;
          cause = CAUSE_STOP;
        end else if (!sum_ok_q) begin
          err   = 1'b1;
          cause = CAUSE_SUM;
        end else begin
          good = 1'b1;
        end
      end
      PH_L_LEN1: begin
        if (rx_byte_i < L_MIN) begin
          err   = 1'b1;
          cause = CAUSE_HEADER;
        end else begin
          phase_d = PH_L_LEN2;
        end
      end
      PH_L_LEN2: begin
        if (rx_byte_i != length_q) begin
          err   = 1'b1;
          cause = CAUSE_HEADER;
        end else begin
          phase_d = PH_L_START2;
        end
      end
      PH_L_START2: begin
        if (rx_byte_i != cfg_i.long_start_code) begin
          err   = 1'b1;
          cause = CAUSE_HEADER;
        end else begin
          phase_d = PH_L_BODY;
        end
      end
      PH_L_BODY: begin
        data = (body_count_q > 8'd2);
        if (body_next == length_q) begin
          phase_d = PH_L_CS;
        end
      end
      PH_L_CS: phase_d = PH_L_STOP;
      default: bad_phase = 1'b1;
    endcase

    // truncation, unless the octet closed the frame or revealed an error
    if (buffer_end_i && !good && !err && !bad_phase) begin
      err   = 1'b1;
      cause = CAUSE_TRUNC;
    end
    if (err) begin
      data = 1'b0;
    end
    if (good || err || bad_phase) begin
      phase_d = PH_HUNT;
    end
  end

  // frame fields and result word
  always_comb begin
    length_d     = length_q;
    body_count_d = body_count_q;
    sum_d        = sum_q;
    ctl_d        = ctl_q;
    addr_d       = addr_q;
    ci_d         = ci_q;
    sum_ok_d     = sum_ok_q;
    result_o     = '0;
    has_result_o = good || err || data;

    case (phase_q) inside
      PH_S_C: begin
        ctl_d = rx_byte_i;
        sum_d = rx_byte_i;
      end
      PH_S_A: begin
        addr_d = rx_byte_i;
        sum_d  = sum_q + rx_byte_i;
      end
      PH_S_CS, PH_L_CS: sum_ok_d = (rx_byte_i == sum_q);
      PH_L_LEN1: length_d = rx_byte_i;
      PH_L_START2: begin
        body_count_d = '0;
        sum_d        = '0;
      end
      PH_L_BODY: begin
        case (body_count_q)
          8'd0:    ctl_d  = rx_byte_i;
          8'd1:    addr_d = rx_byte_i;
          8'd2:    ci_d   = rx_byte_i;
          default: ;
        endcase
        sum_d        = sum_q + rx_byte_i;
        body_count_d = body_next;
      end
      default: ;
    endcase

    if (good) begin
      result_o.frame_done = 1'b1;
      result_o.frame_ok   = 1'b1;
      result_o.frame_kind = kind;
      if (kind == KIND_ACK) begin
        result_o.frame_octets = OCTETS_ACK;
      end else begin
        result_o.control_field = ctl_q;
        result_o.address_field = addr_q;
        if (kind == KIND_LONG) begin
          result_o.ci_field         = ci_q;
          result_o.user_data_length = length_q - L_MIN;
          result_o.frame_octets     = {1'b0, length_q} + FRAME_EXTRA;
        end else begin
          result_o.frame_octets = OCTETS_SHORT;
        end
      end
    end else if (err) begin
      result_o.frame_done  = 1'b1;
      result_o.error_cause = cause;
      result_o.frame_kind  = kind;
    end else if (data) begin
      result_o.data_valid = 1'b1;
      result_o.data_byte  = rx_byte_i;
    end

    if (good || err || bad_phase) begin
      length_d     = '0;
      body_count_d = '0;
      sum_d        = '0;
      ctl_d        = '0;
      addr_d       = '0;
      ci_d         = '0;
      sum_ok_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      length_q     <= '0;
      body_count_q <= '0;
      sum_q        <= '0;
      ctl_q        <= '0;
      addr_q       <= '0;
      ci_q         <= '0;
      sum_ok_q     <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      length_q     <= length_d;
      body_count_q <= body_count_d;
      sum_q        <= sum_d;
      ctl_q        <= ctl_d;
      addr_q       <= addr_d;
      ci_q         <= ci_d;
      sum_ok_q     <= sum_ok_d;
    end
  end

endmodule

### hdl/mbus_frame_deframer.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   rx_byte_i, buffer_end_i
// out      output     out_valid_o/out_ready_i data/frame fields
// cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One word per cycle while in_ready_o is high; each word is parsed in the cycle it is accepted and
// its result (if any) lands in the output register on that edge.
// in_ready_o drops only while a result waits and out_ready_i is low.
// Reset puts the parser in the hunt for a start octet and restores the
// default link codes.
module mbus_frame_deframer import mfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       data_valid_o,
  output logic [7:0] data_byte_o,
  output logic       frame_done_o,
  output logic       frame_ok_o,
  output logic [2:0] error_cause_o,
  output logic [1:0] frame_kind_o,
  output logic [7:0] control_field_o,
  output logic [7:0] address_field_o,
  output logic [7:0] ci_field_o,
  output logic [7:0] user_data_length_o,
  output logic [8:0] frame_octets_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    out_valid_q;
  result_t result_q;
  result_t step_result;
  logic    step_has;
  logic    step;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_code         <= ACK_RST;
      cfg_q.short_start_code <= SHORT_START_RST;
      cfg_q.long_start_code  <= LONG_START_RST;
      cfg_q.stop_code        <= STOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACK:         cfg_q.ack_code         <= cfg_data_i;
        CFG_SHORT_START: cfg_q.short_start_code <= cfg_data_i;
        CFG_LONG_START:  cfg_q.long_start_code  <= cfg_data_i;
        CFG_STOP:        cfg_q.stop_code        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .rx_byte_i    (rx_byte_i),
    .buffer_end_i (buffer_end_i),
    .cfg_i        (cfg_q),
    .has_result_o (step_has),
    .result_o     (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= step_has;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign data_valid_o       = result_q.data_valid;
  assign data_byte_o        = result_q.data_byte;
  assign frame_done_o       = result_q.frame_done;
  assign frame_ok_o         = result_q.frame_ok;
  assign error_cause_o      = result_q.error_cause;
  assign frame_kind_o       = result_q.frame_kind;
  assign control_field_o    = result_q.control_field;
  assign address_field_o    = result_q.address_field;
  assign ci_field_o         = result_q.ci_field;
  assign user_data_length_o = result_q.user_data_length;
  assign frame_octets_o     = result_q.frame_octets;

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (data_valid_o != frame_done_o))
    else $error("result word must be either data or frame-done");

  a_ok_no_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_ok_o) |-> (error_cause_o == CAUSE_NONE && frame_done_o))
    else $error("good frame reported with an error cause");

  a_bad_no_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o && !frame_ok_o) |->
      (frame_octets_o == '0 && control_field_o == '0))
    else $error("failed frame carries frame fields");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while result register is held");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    FLT_NONE,
    FLT_SUM,
    FLT_STOP,
    FLT_BOTH,
    FLT_LEN_LOW,
    FLT_LEN_DIFF,
    FLT_START2
  } fault_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       buffer_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       data_valid_o;
  logic [7:0] data_byte_o;
  logic       frame_done_o;
  logic       frame_ok_o;
  logic [2:0] error_cause_o;
  logic [1:0] frame_kind_o;
  logic [7:0] control_field_o;
  logic [7:0] address_field_o;
  logic [7:0] ci_field_o;
  logic [7:0] user_data_length_o;
  logic [8:0] frame_octets_o;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  mbus_frame_deframer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .buffer_end_i      (buffer_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .data_valid_o      (data_valid_o),
    .data_byte_o       (data_byte_o),
    .frame_done_o      (frame_done_o),
    .frame_ok_o        (frame_ok_o),
    .error_cause_o     (error_cause_o),
    .frame_kind_o      (frame_kind_o),
    .control_field_o   (control_field_o),
    .address_field_o   (address_field_o),
    .ci_field_o        (ci_field_o),
    .user_data_length_o(user_data_length_o),
    .frame_octets_o    (frame_octets_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // link codes and parser state as the block should hold them
  cfg_t       codes;
  phase_e     ph;
  logic [7:0] len_q, body_cnt, sum_q, ctl_q, adr_q, ci_q;
  logic       sum_ok;

  result_t    due_results[$];
  logic [7:0] byte_q[$];

  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_len = 0;
  int n_errors = 0;
  int n_words = 0;
  int n_data = 0;
  int n_good = 0;
  int cause_cnt[6];
  int cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic clear_parse();
    ph       = PH_HUNT;
    len_q    = '0;
    body_cnt = '0;
    sum_q    = '0;
    ctl_q    = '0;
    adr_q    = '0;
    ci_q     = '0;
    sum_ok   = 1'b0;
  endtask

  task automatic close_frame(input logic ok, input logic [2:0] cause, input logic [1:0] kind);
    result_t r;
    r = '0;
    r.frame_done  = 1'b1;
    r.frame_ok    = ok;
    r.error_cause = cause;
    r.frame_kind  = kind;
    if (ok) begin
      if (kind != KIND_ACK) begin
        r.control_field = ctl_q;
        r.address_field = adr_q;
      end
      if (kind == KIND_LONG) begin
        r.ci_field         = ci_q;
        r.user_data_length = len_q - L_MIN;
        r.frame_octets     = {1'b0, len_q} + FRAME_EXTRA;
      end else begin
        r.frame_octets = (kind == KIND_ACK) ? OCTETS_ACK : OCTETS_SHORT;
      end
      n_good++;
    end
    cause_cnt[cause]++;
    due_results.push_back(r);
    clear_parse();
  endtask

  task automatic parse_octet(input logic [7:0] b, input logic last);
    logic [1:0] kind;
    logic       is_data;
    logic       closed;
    result_t    r;
    kind    = (ph >= PH_L_LEN1) ? KIND_LONG : KIND_SHORT;
    is_data = 1'b0;
    closed  = 1'b0;
    case (ph)
      PH_HUNT: begin
        if (b == codes.ack_code) begin
          close_frame(1'b1, CAUSE_NONE, KIND_ACK);
          closed = 1'b1;
        end else if (b == codes.short_start_code) begin
          ph   = PH_S_C;
          kind = KIND_SHORT;
        end else if (b == codes.long_start_code) begin
          ph   = PH_L_LEN1;
          kind = KIND_LONG;
        end else begin
          close_frame(1'b0, CAUSE_START, KIND_ACK);
          closed = 1'b1;
        end
      end
      PH_S_C: begin
        ctl_q = b;
        sum_q = b;
        ph    = PH_S_A;
      end
      PH_S_A: begin
        adr_q = b;
        sum_q = sum_q + b;
        ph    = PH_S_CS;
      end
      PH_S_CS, PH_L_CS: begin
        sum_ok = (b == sum_q);
        ph     = (ph == PH_S_CS) ? PH_S_STOP : PH_L_STOP;
      end
      PH_S_STOP, PH_L_STOP: begin
        closed = 1'b1;
        // a bad stop octet masks a bad checksum
        if (b != codes.stop_code) close_frame(1'b0, CAUSE_STOP, kind);
        else if (!sum_ok) close_frame(1'b0, CAUSE_SUM, kind);
        else close_frame(1'b1, CAUSE_NONE, kind);
      end
      PH_L_LEN1: begin
        if (b < L_MIN) begin
          close_frame(1'b0, CAUSE_HEADER, KIND_LONG);
          closed = 1'b1;
        end else begin
          len_q = b;
          ph    = PH_L_LEN2;
        end
      end
      PH_L_LEN2: begin
        if (b != len_q) begin
          close_frame(1'b0, CAUSE_HEADER, KIND_LONG);
          closed = 1'b1;
        end else begin
          ph = PH_L_START2;
        end
      end
      PH_L_START2: begin
        if (b != codes.long_start_code) begin
          close_frame(1'b0, CAUSE_HEADER, KIND_LONG);
          closed = 1'b1;
        end else begin
          body_cnt = '0;
          sum_q    = '0;
          ph       = PH_L_BODY;
        end
      end
      PH_L_BODY: begin
        if (body_cnt == 8'd0) ctl_q = b;
        else if (body_cnt == 8'd1) adr_q = b;
        else if (body_cnt == 8'd2) ci_q = b;
        else is_data = 1'b1;
        sum_q    = sum_q + b;
        body_cnt = body_cnt + 8'd1;
        if (body_cnt == len_q) ph = PH_L_CS;
      end
      default: begin
        clear_parse();
        closed = 1'b1;
      end
    endcase
    if (!closed) begin
      if (last) begin
        close_frame(1'b0, CAUSE_TRUNC, kind);
      end else if (is_data) begin
        r            = '0;
        r.data_valid = 1'b1;
        r.data_byte  = b;
        due_results.push_back(r);
        n_data++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [8:0] got_v,
                                 input logic [8:0] exp_v);
    n_errors++;
    if (n_errors <= 40)
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got_v, exp_v);
  endtask

  task automatic check_result();
    result_t got, want;
    got = {data_valid_o, data_byte_o, frame_done_o, frame_ok_o, error_cause_o, frame_kind_o,
           control_field_o, address_field_o, ci_field_o, user_data_length_o, frame_octets_o};
    if (due_results.size() == 0) begin
      report_mismatch("result with none pending, frame_done", 9'(got.frame_done), 9'd0);
    end else begin
      want = due_results.pop_front();
      if (got.data_valid !== want.data_valid)
        report_mismatch("data_valid", 9'(got.data_valid), 9'(want.data_valid));
      if (got.data_byte !== want.data_byte)
        report_mismatch("data_byte", 9'(got.data_byte), 9'(want.data_byte));
      if (got.frame_done !== want.frame_done)
        report_mismatch("frame_done", 9'(got.frame_done), 9'(want.frame_done));
      if (got.frame_ok !== want.frame_ok)
        report_mismatch("frame_ok", 9'(got.frame_ok), 9'(want.frame_ok));
      if (got.error_cause !== want.error_cause)
        report_mismatch("error_cause", 9'(got.error_cause), 9'(want.error_cause));
      if (got.frame_kind !== want.frame_kind)
        report_mismatch("frame_kind", 9'(got.frame_kind), 9'(want.frame_kind));
      if (got.control_field !== want.control_field)
        report_mismatch("control_field", 9'(got.control_field), 9'(want.control_field));
      if (got.address_field !== want.address_field)
        report_mismatch("address_field", 9'(got.address_field), 9'(want.address_field));
      if (got.ci_field !== want.ci_field)
        report_mismatch("ci_field", 9'(got.ci_field), 9'(want.ci_field));
      if (got.user_data_length !== want.user_data_length)
        report_mismatch("user_data_length", 9'(got.user_data_length),
                        9'(want.user_data_length));
      if (got.frame_octets !== want.frame_octets)
        report_mismatch("frame_octets", got.frame_octets, want.frame_octets);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
  end

  // receiver side; a requested hold-off keeps ready low for that many cycles
  initial begin
    int n;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // valid stays high on return so a following word can go back to back
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    rx_byte_i    <= b;
    buffer_end_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parse_octet(b, last);
    n_words++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_codes(input cfg_t val);
    logic [7:0] v[4];
    v[0] = val.ack_code;
    v[1] = val.short_start_code;
    v[2] = val.long_start_code;
    v[3] = val.stop_code;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      case (2'(i))
        CFG_ACK:         codes.ack_code = v[i];
        CFG_SHORT_START: codes.short_start_code = v[i];
        CFG_LONG_START:  codes.long_start_code = v[i];
        CFG_STOP:        codes.stop_code = v[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic build_frame(input logic is_long, input logic [7:0] l, input logic [7:0] c,
                             input logic [7:0] a, input fault_e flt, output int n_send);
    logic [7:0] sum, d, ci;
    byte_q.delete();
    ci = 8'($urandom);
    if (!is_long) begin
      byte_q.push_back(codes.short_start_code);
      byte_q.push_back(c);
      byte_q.push_back(a);
      sum = c + a;
    end else begin
      byte_q.push_back(codes.long_start_code);
      byte_q.push_back(l);
      byte_q.push_back(l);
      byte_q.push_back(codes.long_start_code);
      byte_q.push_back(c);
      byte_q.push_back(a);
      byte_q.push_back(ci);
      sum = c + a + ci;
      for (int i = 3; i < l; i++) begin
        d = 8'($urandom);
        byte_q.push_back(d);
        sum = sum + d;
      end
    end
    if (flt == FLT_SUM || flt == FLT_BOTH) sum = sum ^ 8'($urandom_range(1, 255));
    byte_q.push_back(sum);
    if (flt == FLT_STOP || flt == FLT_BOTH)
      byte_q.push_back(codes.stop_code ^ 8'($urandom_range(1, 255)));
    else
      byte_q.push_back(codes.stop_code);
    n_send = byte_q.size();
    case (flt)
      FLT_LEN_LOW: begin
        byte_q[1] = 8'($urandom_range(0, 2));
        n_send = 2;
      end
      FLT_LEN_DIFF: begin
        byte_q[2] = l ^ 8'($urandom_range(1, 255));
        n_send = 3;
      end
      FLT_START2: begin
        byte_q[3] = codes.long_start_code ^ 8'($urandom_range(1, 255));
        n_send = 4;
      end
      default: ;
    endcase
  endtask

  task automatic send_frame(input int n_send, input int cut);
    if (cut >= 0 && cut < n_send) n_send = cut + 1;
    for (int i = 0; i < n_send; i++) send_word(byte_q[i], i == cut);
  endtask

  task automatic send_random_frame();
    int     sel, n_send, cut, r;
    logic   is_long;
    logic [7:0] l;
    fault_e flt;
    sel = $urandom_range(99);
    if (sel < 8) begin
      send_word(8'($urandom), $urandom_range(7) == 0);
    end else if (sel < 15) begin
      send_word(codes.ack_code, $urandom_range(7) == 0);
    end else begin
      is_long = (sel >= 40);
      r = $urandom_range(99);
      if (r < 2) l = 8'd255;
      else if (r < 6) l = 8'($urandom_range(3, 255));
      else l = 8'($urandom_range(3, 16));
      flt = ($urandom_range(99) < 65) ? FLT_NONE
                                      : fault_e'($urandom_range(1, is_long ? 6 : 3));
      build_frame(is_long, l, 8'($urandom), 8'($urandom), flt, n_send);
      cut = ($urandom_range(99) < 10) ? $urandom_range(0, n_send - 1) : -1;
      send_frame(n_send, cut);
    end
  endtask

  task automatic test_directed();
    int n_send;
    send_word(codes.ack_code, 1'b0);
    send_word(8'h00, 1'b1);
    build_frame(1'b0, 8'd0, 8'hFF, 8'hFF, FLT_NONE, n_send);
    send_frame(n_send, -1);
    build_frame(1'b0, 8'd0, 8'h00, 8'h00, FLT_BOTH, n_send);
    send_frame(n_send, -1);
    build_frame(1'b1, 8'd4, 8'h00, 8'hFF, FLT_NONE, n_send);
    send_frame(n_send, -1);
    build_frame(1'b1, 8'd3, 8'h5A, 8'hA5, FLT_LEN_LOW, n_send);
    send_frame(n_send, -1);
    send_word(codes.short_start_code, 1'b1);
    wait_idle();
  endtask

  // output held off long enough that the block backs up onto its input
  task automatic test_backpressure();
    int n_send;
    hold_len = 200;
    build_frame(1'b1, 8'd24, 8'($urandom), 8'($urandom), FLT_NONE, n_send);
    send_frame(n_send, -1);
    wait_idle();
  endtask

  task automatic test_code_overlap();
    int n_send;
    write_codes({8'hA5, 8'hA5, 8'hA5, 8'hA5});
    send_word(8'hA5, 1'b0);
    send_word(8'h16, 1'b0);
    wait_idle();
    write_codes({8'hE5, 8'h33, 8'h33, 8'h16});
    build_frame(1'b0, 8'd0, 8'($urandom), 8'($urandom), FLT_NONE, n_send);
    send_frame(n_send, -1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    cfg_t sets[4];
    int   send_pct[4];
    int   rx_pct[4];
    int   batch_end;
    sets[0] = {ACK_RST, SHORT_START_RST, LONG_START_RST, STOP_RST};
    sets[1] = {8'h00, 8'hFF, 8'h80, 8'h7F};
    sets[2] = {8'hFF, 8'h00, 8'h7F, 8'h80};
    sets[3] = 32'($urandom);
    send_pct = '{0, 72, 0, 30};
    rx_pct   = '{0, 0, 72, 30};
    for (int s = 0; s < 4; s++) begin
      wait_idle();
      write_codes(sets[s]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = send_pct[m];
        rx_stall_pct  = rx_pct[m];
        batch_end = n_words + 24;
        while (n_words < batch_end) send_random_frame();
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    rx_byte_i    <= 8'h00;
    buffer_end_i <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_ACK;
    cfg_data_i   <= 8'h00;
    foreach (cause_cnt[i]) cause_cnt[i] = 0;
    codes = {ACK_RST, SHORT_START_RST, LONG_START_RST, STOP_RST};
    clear_parse();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_code_overlap();
    test_random_traffic();

    send_idle_pct = 0;
    rx_stall_pct  = 0;
    repeat (20) @(posedge clk_i);

    $display("Sent %0d words under four code sets and four idle mixes: %0d data words out,",
             n_words, n_data);
    $display("%0d good frames; causes start/header/stop/sum/trunc %0d/%0d/%0d/%0d/%0d",
             n_good, cause_cnt[CAUSE_START], cause_cnt[CAUSE_HEADER], cause_cnt[CAUSE_STOP],
             cause_cnt[CAUSE_SUM], cause_cnt[CAUSE_TRUNC]);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
